// File: rtl/csfc_pkg.sv
// Types, constants and character class functions for the callsign format check.
`timescale 1ns / 1ps
`default_nettype none

package csfc_pkg;

    localparam int INPUT_CHARS = 13;
    localparam int BASE_CHARS  = 6;
    localparam int MAX_TEXT    = 11;
    localparam int MAX_SUFFIX  = 3;
    localparam int QUIRK_CHARS = 5;

    localparam int IN_WIDTH   = INPUT_CHARS * 8;
    localparam int BASE_WIDTH = BASE_CHARS * 8;

    typedef logic [7:0] char_t;
    typedef logic [3:0] text_len_t;
    typedef logic [2:0] base_len_t;

    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_DOT   = 8'h2E;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_QUERY = 8'h3F;
    localparam char_t CH_Q_UP  = 8'h51;
    localparam char_t CH_Q_LOW = 8'h71;

    localparam logic [QUIRK_CHARS*8-1:0] QUIRK_CALL = {8'h4B, 8'h52, 8'h31, 8'h55, 8'h51};

    function automatic logic is_letter(input char_t c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// File: rtl/callsign_format_check.sv
// Callsign format check: validates a padded text and extracts its base call.
//
// Input channel s_axis carries one 13-character text per transfer, space
// padded, character 1 in the lowest byte. Output channel m_axis carries one
// result per input transfer: the six-character base call in tdata and the
// valid flag in tuser.
//
// The text is captured in an input register, checked by combinational logic
// and written into the result register, from which the result is presented
// on m_axis until the receiver takes it.
// One transfer is accepted every cycle while the receiver takes results; a
// stalled receiver holds the result register, and the input register keeps
// taking a new text until it too is full, after which s_axis_tready drops.
//
// Reset clears both valid flags; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module callsign_format_check
    import csfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_WIDTH-1:0]   s_axis_tdata,   // chars_low[63:0], chars_high[103:64]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [BASE_WIDTH-1:0]      m_axis_tdata,   // base_call[47:0]
    output logic                       m_axis_tuser    // call_ok[0]
);

    logic                  in_valid_reg;
    logic [IN_WIDTH-1:0]   in_data_reg;
    logic                  out_valid_reg;
    logic [BASE_WIDTH-1:0] out_base_reg;
    logic                  out_ok_reg;

    logic                  out_advance;
    logic                  in_advance;

    char_t                 txt        [INPUT_CHARS];
    char_t                 bc         [BASE_CHARS];
    logic [BASE_WIDTH-1:0] base_next;
    logic                  ok_next;
    text_len_t             n1;
    text_len_t             slash;
    text_len_t             left_len;
    text_len_t             right_len;
    text_len_t             start;
    text_len_t             seg_len;
    text_len_t             idx;
    char_t                 pick;
    logic                  bad_char;
    logic                  early_reject;
    logic                  compound;
    logic                  use_right;
    base_len_t             nbc;
    base_len_t             dpos;
    logic                  head_ok;
    logic                  quirk_ok;
    logic                  digit_ok;
    logic                  suffix_ok;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign in_advance    = !in_valid_reg || out_advance;
    assign s_axis_tready = in_advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_base_reg;
    assign m_axis_tuser  = out_ok_reg;

    always_comb
    begin
        for (int i = 0; i < INPUT_CHARS; i++)
        begin
            txt[i] = in_data_reg[8*i +: 8];
        end

        n1 = '0;
        for (int i = 0; i < INPUT_CHARS; i++)
        begin
            if (txt[i] != CH_SPACE)
            begin
                n1 = text_len_t'(i + 1);
            end
        end

        bad_char = 1'b0;
        slash    = '0;
        for (int i = INPUT_CHARS - 1; i >= 0; i--)
        begin
            if (text_len_t'(i) < n1)
            begin
                if (txt[i] == CH_DOT || txt[i] == CH_PLUS ||
                    txt[i] == CH_MINUS || txt[i] == CH_QUERY)
                begin
                    bad_char = 1'b1;
                end
                if (txt[i] == CH_SLASH)
                begin
                    slash = text_len_t'(i + 1);
                end
            end
        end

        left_len  = (slash != '0) ? slash - 4'd1 : n1;
        right_len = (slash != '0) ? n1 - slash : '0;

        early_reject = (n1 > text_len_t'(MAX_TEXT)) || bad_char ||
                       ((n1 > text_len_t'(BASE_CHARS)) && (slash == '0)) ||
                       (left_len > text_len_t'(BASE_CHARS)) ||
                       (right_len > text_len_t'(BASE_CHARS));

        compound  = !early_reject && (slash >= 4'd2) && (slash < n1);
        use_right = left_len <= right_len;
        start     = use_right ? slash : '0;
        seg_len   = use_right ? right_len : left_len;

        for (int i = 0; i < BASE_CHARS; i++)
        begin
            idx  = start + text_len_t'(i);
            pick = CH_SPACE;
            for (int j = 0; j < INPUT_CHARS; j++)
            begin
                if (idx == text_len_t'(j))
                begin
                    pick = txt[j];
                end
            end
            if (!compound)
            begin
                bc[i] = txt[i];
            end
            else if (text_len_t'(i) < seg_len)
            begin
                bc[i] = pick;
            end
            else
            begin
                bc[i] = CH_SPACE;
            end
        end

        nbc = '0;
        for (int i = 0; i < BASE_CHARS; i++)
        begin
            if (bc[i] != CH_SPACE)
            begin
                nbc = base_len_t'(i + 1);
            end
        end

        head_ok = is_letter(bc[0]) || ((nbc >= 3'd2) && is_letter(bc[1]));

        quirk_ok = 1'b1;
        if (bc[0] == CH_Q_UP || bc[0] == CH_Q_LOW)
        begin
            for (int i = 0; i < QUIRK_CHARS; i++)
            begin
                if (bc[i] != QUIRK_CALL[8*i +: 8])
                begin
                    quirk_ok = 1'b0;
                end
            end
        end

        if ((nbc >= 3'd3) && is_digit(bc[2]))
        begin
            dpos = 3'd3;
        end
        else if ((nbc >= 3'd2) && is_digit(bc[1]))
        begin
            dpos = 3'd2;
        end
        else
        begin
            dpos = 3'd0;
        end

        digit_ok = (dpos != 3'd0) && (dpos < nbc) &&
                   ((nbc - dpos) <= base_len_t'(MAX_SUFFIX));

        suffix_ok = 1'b1;
        for (int i = 0; i < BASE_CHARS; i++)
        begin
            if ((base_len_t'(i) >= dpos) && (base_len_t'(i) < nbc) && !is_letter(bc[i]))
            begin
                suffix_ok = 1'b0;
            end
        end

        for (int i = 0; i < BASE_CHARS; i++)
        begin
            base_next[8*i +: 8] = bc[i];
        end

        ok_next = !early_reject && head_ok && quirk_ok && digit_ok && suffix_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (out_advance && in_valid_reg)
        begin
            out_base_reg <= base_next;
            out_ok_reg   <= ok_next;
        end
    end

endmodule

`default_nettype wire
